// ----- hdl/hrhp_pkg.sv -----
// Package: payload types and codes for the HTTP response header parser.
`default_nettype none
package hrhp_pkg;
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } hrhp_in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [2:0] error_code;
    logic       body_valid;
    logic [7:0] body_byte;
    logic [9:0] status_code;
    logic       keepalive;
    logic       version_is_11;
  } hrhp_out_t;

  typedef enum logic [3:0] {
    PH_PROTO   = 4'd0,
    PH_VERSION = 4'd1,
    PH_STATUS  = 4'd2,
    PH_REASON  = 4'd3,
    PH_KEY     = 4'd4,
    PH_VALUE   = 4'd5,
    PH_LINEEND = 4'd6,
    PH_BODY    = 4'd7,
    PH_DONE    = 4'd8,
    PH_ERROR   = 4'd9
  } hrhp_phase_t;

  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_CLOSE   = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } hrhp_op_t;

  localparam logic [1:0] RK_PARSING = 2'd0;
  localparam logic [1:0] RK_DONE    = 2'd1;
  localparam logic [1:0] RK_ERROR   = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TOKEN     = 3'd1;
  localparam logic [2:0] ERR_NOT_HTTP  = 3'd2;
  localparam logic [2:0] ERR_VERSION   = 3'd3;
  localparam logic [2:0] ERR_STATUS    = 3'd4;
  localparam logic [2:0] ERR_NO_LENGTH = 3'd5;
  localparam logic [2:0] ERR_TRUNC     = 3'd6;

  // classified byte handed from front to back
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       is_cr;
    logic       is_lf;
    logic       is_space;
    logic       is_colon;
    logic       is_slash;
    logic       is_digit;
    logic [3:0] digit;
  } hrhp_cls_t;

  function automatic logic [7:0] key_clen_char(input logic [3:0] p);
    logic [7:0] c;
    begin
      case (p)
        4'd0: c = "C";  4'd1: c = "o";  4'd2: c = "n";  4'd3: c = "t";
        4'd4: c = "e";  4'd5: c = "n";  4'd6: c = "t";  4'd7: c = "-";
        4'd8: c = "L";  4'd9: c = "e";  4'd10: c = "n"; 4'd11: c = "g";
        4'd12: c = "t"; 4'd13: c = "h";
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

  function automatic logic [7:0] key_conn_char(input logic [3:0] p);
    logic [7:0] c;
    begin
      case (p)
        4'd0: c = "C"; 4'd1: c = "o"; 4'd2: c = "n"; 4'd3: c = "n";
        4'd4: c = "e"; 4'd5: c = "c"; 4'd6: c = "t"; 4'd7: c = "i";
        4'd8: c = "o"; 4'd9: c = "n";
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

  function automatic logic [7:0] val_close_char(input logic [2:0] p);
    logic [7:0] c;
    begin
      case (p)
        3'd0: c = "c"; 3'd1: c = "l"; 3'd2: c = "o"; 3'd3: c = "s"; 3'd4: c = "e";
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction
endpackage
`default_nettype wire

// ----- hdl/hrhp_front.sv -----
// Front end: accepts input beats and classifies each byte.
`default_nettype none
module hrhp_front
  import hrhp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire hrhp_in_t  in_data,
  output logic           cls_valid,
  input  wire logic      cls_ready,
  output hrhp_cls_t      cls_data
);
  logic      cls_valid_r, cls_valid_nxt;
  hrhp_cls_t cls_data_r, cls_data_nxt;
  logic      take;

  assign in_ready = !cls_valid_r || cls_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    cls_data_nxt.opcode    = in_data.opcode;
    cls_data_nxt.data_byte = in_data.data_byte;
    cls_data_nxt.is_cr     = in_data.data_byte == 8'h0D;
    cls_data_nxt.is_lf     = in_data.data_byte == 8'h0A;
    cls_data_nxt.is_space  = in_data.data_byte == 8'h20;
    cls_data_nxt.is_colon  = in_data.data_byte == 8'h3A;
    cls_data_nxt.is_slash  = in_data.data_byte == 8'h2F;
    cls_data_nxt.is_digit  = in_data.data_byte inside {[8'h30:8'h39]};
    cls_data_nxt.digit     = in_data.data_byte[3:0];
    cls_valid_nxt = take ? 1'b1 : (cls_ready ? 1'b0 : cls_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_valid_r <= 1'b0;
    end else begin
      cls_valid_r <= cls_valid_nxt;
    end
    if (take) begin
      cls_data_r <= cls_data_nxt;
    end
  end

  assign cls_valid = cls_valid_r;
  assign cls_data  = cls_data_r;
endmodule
`default_nettype wire

// ----- hdl/hrhp_fifo.sv -----
// Short queue between front and back ends.
`default_nettype none
module hrhp_fifo
  import hrhp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  wire hrhp_cls_t wr_data,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output hrhp_cls_t      rd_data
);
  hrhp_cls_t  mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/hrhp_back.sv -----
// Back end: the parse state machine and the result register.
`default_nettype none
module hrhp_back
  import hrhp_pkg::*;
#(
  parameter int TOKEN_LIMIT  = 4096,
  parameter int LENGTH_WIDTH = 40
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      keep_init,
  input  wire logic      cls_valid,
  output logic           cls_ready,
  input  wire hrhp_cls_t cls_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output hrhp_out_t      out_data
);
  localparam int TW = $clog2(TOKEN_LIMIT + 1);
  localparam logic [TW-1:0] TLIM = TW'(TOKEN_LIMIT);
  localparam logic [LENGTH_WIDTH-1:0] LMAX = {LENGTH_WIDTH{1'b1}};
  // largest value that can take another digit without overflow bound check
  localparam logic [LENGTH_WIDTH-1:0] LDIV = LMAX / 10;
  localparam logic [3:0] LREM = 4'(LMAX % 10);

  hrhp_phase_t phase_r, phase_nxt;
  logic [TW-1:0] tok_r, tok_nxt;
  logic [31:0] lf_r, lf_nxt;
  logic clen_r, clen_nxt, conn_r, conn_nxt, close_r, close_nxt, dig_r, dig_nxt;
  logic [LENGTH_WIDTH-1:0] len_r, len_nxt, cnt_r, cnt_nxt;
  logic [9:0] status_r, status_nxt;
  logic keep_r, keep_nxt, v11_r, v11_nxt;
  logic [2:0] err_r, err_nxt;
  logic out_valid_r, out_valid_nxt;
  hrhp_out_t out_r, out_nxt;
  logic take, bvalid;

  logic [LENGTH_WIDTH+3:0] len_x10;
  logic [9:0] st_sum;

  assign cls_ready = !out_valid_r || out_ready;
  assign take      = cls_valid && cls_ready;

  // digit accumulate: shifts and add only
  assign len_x10 = {len_r, 3'b000} + {3'b000, len_r, 1'b0} +
                   {{LENGTH_WIDTH{1'b0}}, cls_data.digit};
  assign st_sum = 10'(lf_r[19:16]) * 10'd100 + 10'(lf_r[11:8]) * 10'd10 +
                  10'(lf_r[3:0]);

  always_comb begin
    logic [3:0] p;
    logic [7:0] b;
    logic tokfull;
    p = tok_r[3:0];
    b = cls_data.data_byte;
    tokfull = tok_r >= TLIM;
    phase_nxt = phase_r; tok_nxt = tok_r; lf_nxt = lf_r;
    clen_nxt = clen_r; conn_nxt = conn_r; close_nxt = close_r; dig_nxt = dig_r;
    len_nxt = len_r; cnt_nxt = cnt_r; status_nxt = status_r;
    keep_nxt = keep_r; v11_nxt = v11_r; err_nxt = err_r;
    bvalid = 1'b0;
    case (hrhp_op_t'(cls_data.opcode))
      OP_RESTART: begin
        phase_nxt = PH_PROTO; tok_nxt = '0; lf_nxt = '0;
        clen_nxt = 1'b1; conn_nxt = 1'b1; close_nxt = 1'b0; dig_nxt = 1'b0;
        len_nxt = '0; cnt_nxt = '0; status_nxt = '0;
        keep_nxt = keep_init; v11_nxt = 1'b0; err_nxt = ERR_NONE;
      end
      OP_CLOSE: begin
        if (phase_r == PH_BODY) begin
          phase_nxt = PH_DONE;
        end else if (phase_r != PH_DONE && phase_r != PH_ERROR) begin
          phase_nxt = PH_ERROR; err_nxt = ERR_TRUNC;
        end
      end
      OP_DATA: begin
        if (phase_r == PH_BODY) begin
          bvalid = 1'b1;
          if (cnt_r != LMAX) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (len_r != '0 && cnt_nxt >= len_r) begin
            phase_nxt = PH_DONE;
          end
        end else if (phase_r < PH_BODY && !cls_data.is_cr) begin
          if (tokfull) begin
            phase_nxt = PH_ERROR; err_nxt = ERR_TOKEN;
          end else begin
            // token push defaults; arms override
            case (phase_r)
              PH_PROTO: begin
                if (cls_data.is_slash) begin
                  if (tok_r == TW'(4) && lf_r == 32'h48545450) begin
                    tok_nxt = '0; lf_nxt = '0; phase_nxt = PH_VERSION;
                  end else begin
                    phase_nxt = PH_ERROR; err_nxt = ERR_NOT_HTTP;
                  end
                end else begin
                  lf_nxt = {lf_r[23:0], b}; tok_nxt = tok_r + 1'b1;
                end
              end
              PH_VERSION: begin
                if (cls_data.is_space) begin
                  if (tok_r == TW'(3) &&
                      (lf_r[23:0] == 24'h312E30 || lf_r[23:0] == 24'h312E31)) begin
                    if (lf_r[0]) v11_nxt = 1'b1;
                    tok_nxt = '0; lf_nxt = '0; phase_nxt = PH_STATUS;
                  end else begin
                    phase_nxt = PH_ERROR; err_nxt = ERR_VERSION;
                  end
                end else begin
                  lf_nxt = {lf_r[23:0], b}; tok_nxt = tok_r + 1'b1;
                end
              end
              PH_STATUS: begin
                if (cls_data.is_space) begin
                  if (tok_r == TW'(3) &&
                      lf_r[23:16] inside {[8'h30:8'h39]} &&
                      lf_r[15:8] inside {[8'h30:8'h39]} &&
                      lf_r[7:0] inside {[8'h30:8'h39]}) begin
                    status_nxt = st_sum;
                    tok_nxt = '0; lf_nxt = '0; phase_nxt = PH_REASON;
                  end else begin
                    phase_nxt = PH_ERROR; err_nxt = ERR_STATUS;
                  end
                end else begin
                  lf_nxt = {lf_r[23:0], b}; tok_nxt = tok_r + 1'b1;
                end
              end
              PH_REASON: begin
                if (cls_data.is_lf) phase_nxt = PH_LINEEND;
              end
              PH_VALUE: begin
                if (cls_data.is_lf) begin
                  if (conn_r && close_r && tok_r >= TW'(5)) keep_nxt = 1'b0;
                  tok_nxt = '0; lf_nxt = '0; phase_nxt = PH_LINEEND;
                end else if (!(tok_r == '0 && cls_data.is_space)) begin
                  if (tok_r < TW'(5) && b != val_close_char(p[2:0])) close_nxt = 1'b0;
                  if (clen_r && dig_r) begin
                    if (cls_data.is_digit) begin
                      if (len_r > LDIV || (len_r == LDIV && cls_data.digit > LREM)) begin
                        len_nxt = LMAX;
                      end else begin
                        len_nxt = len_x10[LENGTH_WIDTH-1:0];
                      end
                    end else begin
                      dig_nxt = 1'b0;
                    end
                  end
                  lf_nxt = {lf_r[23:0], b}; tok_nxt = tok_r + 1'b1;
                end
              end
              PH_LINEEND: begin
                if (cls_data.is_lf) begin
                  if (len_r == '0 && v11_r) begin
                    phase_nxt = PH_ERROR; err_nxt = ERR_NO_LENGTH;
                  end else begin
                    phase_nxt = PH_BODY;
                  end
                end else if (cls_data.is_colon) begin
                  // empty key
                  clen_nxt = 1'b0; conn_nxt = 1'b0; close_nxt = 1'b0; dig_nxt = 1'b0;
                  tok_nxt = '0; lf_nxt = '0; phase_nxt = PH_VALUE;
                end else begin
                  clen_nxt = b == key_clen_char(4'd0);
                  conn_nxt = b == key_conn_char(4'd0);
                  tok_nxt = TW'(1); lf_nxt = {24'h0, b}; phase_nxt = PH_KEY;
                end
              end
              default: begin // PH_KEY
                if (cls_data.is_colon) begin
                  clen_nxt = clen_r && tok_r == TW'(14);
                  dig_nxt = clen_nxt;
                  conn_nxt = conn_r && tok_r >= TW'(10);
                  close_nxt = conn_nxt;
                  if (clen_nxt) len_nxt = '0;
                  tok_nxt = '0; lf_nxt = '0; phase_nxt = PH_VALUE;
                end else begin
                  if (tok_r >= TW'(14) || b != key_clen_char(p)) clen_nxt = 1'b0;
                  if (tok_r < TW'(10) && b != key_conn_char(p)) conn_nxt = 1'b0;
                  lf_nxt = {lf_r[23:0], b}; tok_nxt = tok_r + 1'b1;
                end
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
    out_nxt.result_kind = phase_nxt == PH_ERROR ? RK_ERROR :
                          (phase_nxt == PH_DONE ? RK_DONE : RK_PARSING);
    out_nxt.error_code    = phase_nxt == PH_ERROR ? err_nxt : ERR_NONE;
    out_nxt.body_valid    = bvalid;
    out_nxt.body_byte     = bvalid ? b : 8'h00;
    out_nxt.status_code   = status_nxt;
    out_nxt.keepalive     = keep_nxt;
    out_nxt.version_is_11 = v11_nxt;
    out_valid_nxt = take ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PROTO; tok_r <= '0; lf_r <= '0;
      clen_r <= 1'b1; conn_r <= 1'b1; close_r <= 1'b0; dig_r <= 1'b0;
      len_r <= '0; cnt_r <= '0; status_r <= '0;
      keep_r <= 1'b1; v11_r <= 1'b0; err_r <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        phase_r <= phase_nxt; tok_r <= tok_nxt; lf_r <= lf_nxt;
        clen_r <= clen_nxt; conn_r <= conn_nxt; close_r <= close_nxt;
        dig_r <= dig_nxt; len_r <= len_nxt; cnt_r <= cnt_nxt;
        status_r <= status_nxt; keep_r <= keep_nxt; v11_r <= v11_nxt;
        err_r <= err_nxt;
      end
    end
    if (take) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

// ----- hdl/http_response_header_parser_unit.sv -----
// Top level of the HTTP response header parser.
// Takes one beat per clock while not held off: each beat is a response byte, a
// connection-close event or a restart, and yields exactly one result beat. The
// beat passes the front register, the queue and the back end result
// register before its result appears; it waits while the output is held off.
// Sustained rate is one beat per cycle while the output is taken, set by the parse
// state machine in the back end updating once per beat. A front stage classifies
// bytes, a two-entry queue decouples it from the back end, and a registered result
// stage holds each result until taken; while one waits, the back end stalls.
// cfg_data sets request_is_http11 (reset 1); it takes effect at the next
// restart beat. Write it only while idle.
`default_nettype none
module http_response_header_parser_unit
  import hrhp_pkg::*;
#(
  parameter int TOKEN_LIMIT  = 4096,
  parameter int LENGTH_WIDTH = 40
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire hrhp_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output hrhp_out_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);
  logic      f_valid, f_ready, q_valid, q_ready;
  hrhp_cls_t f_data, q_data;
  logic      req11_r, req11_nxt;

  // config register, always writable
  assign cfg_ready = 1'b1;
  assign req11_nxt = cfg_valid ? cfg_data : req11_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req11_r <= 1'b1;
    end else begin
      req11_r <= req11_nxt;
    end
  end

  hrhp_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cls_valid(f_valid), .cls_ready(f_ready), .cls_data(f_data)
  );

  hrhp_fifo u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  hrhp_back #(
    .TOKEN_LIMIT(TOKEN_LIMIT), .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_back (
    .clk, .rst_n, .keep_init(req11_r),
    .cls_valid(q_valid), .cls_ready(q_ready), .cls_data(q_data),
    .out_valid, .out_ready, .out_data
  );
endmodule
`default_nettype wire

// ----- tb/http_response_header_parser_unit_tb.sv -----
// Testbench for the HTTP response header parser: byte stream in, parse status out.
`timescale 1ns / 100ps
`default_nettype none
module http_response_header_parser_unit_tb
  import hrhp_pkg::*;
;

  localparam int TOKEN_MAX   = 4096;
  localparam int LEN_W       = 40;
  localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};
  localparam int WATCHDOG    = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hrhp_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hrhp_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  http_response_header_parser_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Parser shadow state, updated once per accepted input beat.
  // ---------------------------------------------------------------------------
  logic               req_http11;
  hrhp_phase_t        phase;
  int unsigned        tok_len;
  logic [31:0]        tail4;
  logic               m_clen, m_conn, m_close, m_digits;
  logic [LEN_W-1:0]   content_len;
  logic [LEN_W-1:0]   body_seen;
  logic [9:0]         status_q;
  logic               keep_q, v11_q;
  logic [2:0]         err_q;

  hrhp_out_t          result_fifo[$];   // expected result beats, oldest first
  hrhp_in_t           send_fifo[$];     // beats waiting for the driver

  int  errors = 0;
  int  idle_cycles = 0;
  int  in_idle_pct = 0;    // sender idle chance, percent
  int  out_stall_pct = 0;  // receiver stall chance, percent
  bit  hold_out = 1'b0;    // long receiver hold-off request
  int  hold_cnt = 0;

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] clen_key(int p);
    string s = "Content-Length";
    return s[p];
  endfunction

  function automatic logic [7:0] conn_key(int p);
    string s = "Connection";
    return s[p];
  endfunction

  function automatic logic [7:0] close_val(int p);
    string s = "close";
    return s[p];
  endfunction

  task automatic tok_clear();
    tok_len = 0;
    tail4 = '0;
  endtask

  task automatic tok_push(logic [7:0] b);
    tail4 = {tail4[23:0], b};
    if (tok_len < TOKEN_MAX) tok_len++;
  endtask

  task automatic go_error(logic [2:0] code);
    err_q = code;
    phase = PH_ERROR;
  endtask

  task automatic shadow_restart();
    phase = PH_PROTO;
    tok_clear();
    m_clen = 1'b1; m_conn = 1'b1; m_close = 1'b0; m_digits = 1'b0;
    content_len = '0;
    body_seen = '0;
    status_q = '0;
    keep_q = req_http11;
    v11_q = 1'b0;
    err_q = ERR_NONE;
  endtask

  task automatic key_char(logic [7:0] b);
    int unsigned p;
    bit nc, nn;
    p = tok_len;
    if (b == ":") begin
      nc = m_clen && p == 14;
      nn = m_conn && p >= 10;
      m_clen = nc; m_digits = nc;
      m_conn = nn; m_close = nn;
      if (nc) content_len = '0;
      tok_clear();
      phase = PH_VALUE;
    end else begin
      if (p >= 14 || b != clen_key(p)) m_clen = 1'b0;
      if (p < 10 && b != conn_key(p)) m_conn = 1'b0;
      tok_push(b);
    end
  endtask

  task automatic value_char(logic [7:0] b);
    int unsigned p;
    logic [LEN_W-1:0] d;
    p = tok_len;
    if (b == 8'h0A) begin
      if (m_conn && m_close && p >= 5) keep_q = 1'b0;
      tok_clear();
      phase = PH_LINEEND;
    end else if (!(p == 0 && b == " ")) begin
      if (p < 5 && b != close_val(p)) m_close = 1'b0;
      if (m_clen && m_digits) begin
        if (is_dig(b)) begin
          d = LEN_W'(b - "0");
          if (content_len > (LEN_SAT - d) / 10) content_len = LEN_SAT;
          else content_len = content_len * 10 + d;
        end else begin
          m_digits = 1'b0;
        end
      end
      tok_push(b);
    end
  endtask

  task automatic header_char(logic [7:0] b);
    logic [31:0] lf;
    lf = tail4;
    case (phase)
      PH_PROTO:
        if (b == "/") begin
          if (tok_len == 4 && lf == "HTTP") begin
            tok_clear(); phase = PH_VERSION;
          end else go_error(ERR_NOT_HTTP);
        end else tok_push(b);
      PH_VERSION:
        if (b == " ") begin
          if (tok_len == 3 && (lf[23:0] == "1.0" || lf[23:0] == "1.1")) begin
            if (lf[23:0] == "1.1") v11_q = 1'b1;
            tok_clear(); phase = PH_STATUS;
          end else go_error(ERR_VERSION);
        end else tok_push(b);
      PH_STATUS:
        if (b == " ") begin
          if (tok_len == 3 && is_dig(lf[23:16]) && is_dig(lf[15:8]) && is_dig(lf[7:0])) begin
            status_q = 10'((lf[23:16] - "0") * 100 + (lf[15:8] - "0") * 10 + (lf[7:0] - "0"));
            tok_clear(); phase = PH_REASON;
          end else go_error(ERR_STATUS);
        end else tok_push(b);
      PH_REASON:
        if (b == 8'h0A) phase = PH_LINEEND;
      PH_KEY:   key_char(b);
      PH_VALUE: value_char(b);
      default: begin
        // line end: blank line closes the header block
        if (b == 8'h0A) begin
          if (content_len == 0 && v11_q) go_error(ERR_NO_LENGTH);
          else phase = PH_BODY;
        end else begin
          m_clen = 1'b1; m_conn = 1'b1;
          tok_clear();
          phase = PH_KEY;
          key_char(b);
        end
      end
    endcase
  endtask

  // Apply one beat to the shadow state and queue the result it must produce.
  task automatic predict_beat(hrhp_in_t beat);
    hrhp_out_t r;
    bit bv;
    bv = 1'b0;
    case (hrhp_op_t'(beat.opcode))
      OP_RESTART: shadow_restart();
      OP_CLOSE: begin
        if (phase == PH_BODY) phase = PH_DONE;
        else if (phase != PH_DONE && phase != PH_ERROR) go_error(ERR_TRUNC);
      end
      OP_DATA: begin
        if (phase == PH_BODY) begin
          bv = 1'b1;
          if (body_seen < LEN_SAT) body_seen++;
          if (content_len > 0 && body_seen >= content_len) phase = PH_DONE;
        end else if (phase < PH_BODY && beat.data_byte != 8'h0D) begin
          if (tok_len >= TOKEN_MAX) go_error(ERR_TOKEN);
          else header_char(beat.data_byte);
        end
      end
      default: ;
    endcase
    r.result_kind   = phase == PH_ERROR ? RK_ERROR : (phase == PH_DONE ? RK_DONE : RK_PARSING);
    r.error_code    = phase == PH_ERROR ? err_q : ERR_NONE;
    r.body_valid    = bv;
    r.body_byte     = bv ? beat.data_byte : 8'h00;
    r.status_code   = status_q;
    r.keepalive     = keep_q;
    r.version_is_11 = v11_q;
    result_fifo.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders: push beats onto the send queue.
  // ---------------------------------------------------------------------------
  task automatic put(hrhp_op_t op, logic [7:0] b);
    hrhp_in_t x;
    x.opcode = op;
    x.data_byte = b;
    send_fifo.push_back(x);
  endtask

  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++) put(OP_DATA, s[i]);
  endtask

  // Random byte with a bias toward CR/LF
  function automatic logic [7:0] rand_byte();
    int k;
    k = $urandom_range(0, 9);
    return k == 0 ? 8'h0D : (k == 1 ? 8'h0A : 8'($urandom));
  endfunction

  // Well-formed response with random content and occasional corruption.
  task automatic put_response();
    string hdr;
    int n, blen, flavor;
    flavor = $urandom_range(0, 9);
    put(OP_RESTART, 8'($urandom));
    hdr = $sformatf("HTTP/1.%0d %0d%0d%0d OK\r\n", $urandom_range(0, 1),
                    $urandom_range(0, 9), $urandom_range(0, 9), $urandom_range(0, 9));
    if (flavor == 0) hdr = "HTTP/2.0 200 OK\r\n";
    if (flavor == 1) hdr = "HTXP/1.1 200 OK\r\n";
    if (flavor == 2) hdr = "HTTP/1.1 2a0 OK\r\n";
    put_str(hdr);
    blen = $urandom_range(0, 12);
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 4))
        0: put_str($sformatf("Content-Length: %0d\r\n", blen));
        1: put_str("Connection: close\r\n");
        2: put_str("Connection: keep-alive\r\n");
        3: put_str($sformatf("Content-Lengthx:%0d\r\n", blen));
        default: put_str("X-Foo: bar\r\n");
      endcase
    end
    if ($urandom_range(0, 1)) put_str($sformatf("Content-Length:  %0d\n", blen));
    put_str("\r\n");
    for (int i = 0; i < blen + $urandom_range(0, 2); i++) put(OP_DATA, 8'($urandom));
    if ($urandom_range(0, 2) == 0) put(OP_CLOSE, 8'($urandom));
    if ($urandom_range(0, 4) == 0) put(OP_NONE, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Clock, driver, monitor, watchdog.
  // ---------------------------------------------------------------------------
  initial begin
    forever #1 clk = ~clk;
  end

  // Driver: one beat per handshake, valid held until accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_beat(in_data);
      if (!in_valid || in_ready) begin
        if (send_fifo.size() > 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          in_data <= send_fifo.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off counted here; the stimulus only requests it.
  always @(posedge clk) begin
    if (hold_out && hold_cnt < 200) hold_cnt <= hold_cnt + 1;
  end

  // Monitor: compare each result beat with the oldest expectation.
  always @(posedge clk) begin
    hrhp_out_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (result_fifo.size() == 0) begin
          $display("%0t: unexpected result beat %p", $time, out_data);
          errors++;
        end else begin
          exp_r = result_fifo.pop_front();
          if (out_data.result_kind !== exp_r.result_kind)
            $display("%0t: result_kind exp %0d got %0d", $time, exp_r.result_kind, out_data.result_kind);
          if (out_data.error_code !== exp_r.error_code)
            $display("%0t: error_code exp %0d got %0d", $time, exp_r.error_code, out_data.error_code);
          if (out_data.body_valid !== exp_r.body_valid)
            $display("%0t: body_valid exp %0d got %0d", $time, exp_r.body_valid, out_data.body_valid);
          if (out_data.body_byte !== exp_r.body_byte)
            $display("%0t: body_byte exp %h got %h", $time, exp_r.body_byte, out_data.body_byte);
          if (out_data.status_code !== exp_r.status_code)
            $display("%0t: status_code exp %0d got %0d", $time, exp_r.status_code, out_data.status_code);
          if (out_data.keepalive !== exp_r.keepalive)
            $display("%0t: keepalive exp %0d got %0d", $time, exp_r.keepalive, out_data.keepalive);
          if (out_data.version_is_11 !== exp_r.version_is_11)
            $display("%0t: version_is_11 exp %0d got %0d", $time, exp_r.version_is_11, out_data.version_is_11);
          if (out_data !== exp_r) errors++;
        end
      end
      out_ready <= !(hold_out && hold_cnt < 200) && $urandom_range(0, 99) >= out_stall_pct;
    end
  end

  // Watchdog: cycles with no beat moving on any channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("FAIL");
      $finish;
    end
  end

  // Wait until the queues drain, then a few more cycles so the block is idle.
  task automatic drain();
    while (send_fifo.size() > 0 || in_valid || result_fifo.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Config write; a restart beat must follow for it to matter.
  task automatic write_cfg(logic v);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    req_http11 = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    req_http11 = 1'b1;
    shadow_restart();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: header handling, errors, every opcode, byte extremes.
    put_str("HTTP/1.1 404 Not Found\r\nContent-Length: 3\r\nConnection: close\r\n\r\n");
    put(OP_DATA, 8'h00); put(OP_DATA, 8'hFF); put(OP_DATA, 8'h0D);
    put(OP_DATA, 8'h41); put(OP_CLOSE, 8'h00); put(OP_NONE, 8'hFF);
    drain();

    write_cfg(1'b0);
    put(OP_RESTART, 8'hFF);
    put_str("HTTP/1.0 200 OK\n\n");               // no headers, version 1.0
    put(OP_DATA, 8'hAA); put(OP_CLOSE, 8'h00);   // close ends body
    put(OP_RESTART, 8'h00);
    put_str("HTTP/1.1 200 OK\n\n");               // missing length
    put(OP_RESTART, 8'h00); put_str("HTTPS/");    // not HTTP
    put(OP_RESTART, 8'h00); put_str("HTTP/1.2 ");  // bad version
    put(OP_RESTART, 8'h00); put_str("HTTP/1.1 20 ");  // bad status
    put(OP_RESTART, 8'h00); put_str("HTTP/1.1 200 ok\n"); put(OP_CLOSE, 8'h00);
    put(OP_RESTART, 8'h00);
    put_str("HTTP/1.1 999 x\nContent-Length: 99999999999999999\n\n");  // saturates
    put(OP_DATA, 8'h55);
    drain();

    write_cfg(1'b1);
    put(OP_RESTART, 8'h00);
    drain();

    // Random phases with different idle patterns.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 79; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 79; end
        3: begin in_idle_pct = 20; out_stall_pct = 20; end
        default: begin in_idle_pct = 0; out_stall_pct = 0; hold_out = 1'b1; end
      endcase
      write_cfg(1'($urandom));
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(0, 9) == 0)
          for (int j = 0; j < 10; j++) put(hrhp_op_t'($urandom_range(0, 3)), rand_byte());
        else
          put_response();
      end
      drain();
      hold_out = 1'b0;
    end

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
hdl/hrhp_pkg.sv
hdl/hrhp_front.sv
hdl/hrhp_fifo.sv
hdl/hrhp_back.sv
hdl/http_response_header_parser_unit.sv
tb/http_response_header_parser_unit_tb.sv
